// ===== rtl/dl2n_pkg.sv =====
// shared widths, register indexes and constants of the l2 normalizer
package dl2n_pkg;

	// field widths
	localparam int QV_W       = 8;
	localparam int DIFF_W     = 9;
	localparam int MAG_W      = 8;
	localparam int SQ_W       = 16;
	localparam int UNIT_W     = 16;
	localparam int POS_W      = 6;
	localparam int VLEN_W     = 7;
	localparam int ZP_W       = 8;
	localparam int SCALE_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// bit-serial datapath widths
	localparam int QUO_W  = 33;
	localparam int ROOT_W = 17;
	localparam int RAD_W  = 34;
	localparam int SC2_W  = 18;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEQUANT_SCALE = 2'd2;

	// register reset values
	localparam logic [VLEN_W-1:0]  VLEN_RESET  = 7'd64;
	localparam logic [ZP_W-1:0]    ZP_RESET    = 8'd0;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h1000_0000;

	// small norm limits: scale^2 * sum <= 2^56 * 1e-12 in q4.28
	localparam logic [SCALE_W-1:0] SMALL_SCALE_MAX = 32'd268;
	localparam int                 SMALL_PROD_MAX  = 72057;

	localparam logic [UNIT_W-1:0] UNIT_MAX = 16'h7FFF;

endpackage

// ===== rtl/dl2n_if.sv =====
// valid/ready channel interfaces of the l2 normalizer

interface dl2n_item_if;
	logic                                valid;
	logic                                ready;
	logic signed [dl2n_pkg::QV_W-1:0]   quant_value;
	logic                                is_final;

	modport source(output valid, quant_value, is_final, input ready);
	modport sink(input valid, quant_value, is_final, output ready);
endinterface

interface dl2n_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [dl2n_pkg::UNIT_W-1:0] unit_value;
	logic [dl2n_pkg::POS_W-1:0]         position;
	logic                                end_of_vector;

	modport source(output valid, unit_value, position, end_of_vector, input ready);
	modport sink(input valid, unit_value, position, end_of_vector, output ready);
endinterface

interface dl2n_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [dl2n_pkg::CFG_IDX_W-1:0]     index;
	logic [dl2n_pkg::CFG_DATA_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/dl2n_divider.sv =====
// bit-serial restoring divider: floor(sq * 2^32 / divisor), one quotient bit per cycle
module dl2n_divider #(
	parameter int SUM_W = 22
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [dl2n_pkg::SQ_W-1:0]      sq,
	input  logic [SUM_W-1:0]               divisor,
	output logic                           done,
	output logic [dl2n_pkg::QUO_W-1:0]     quo
);

	localparam int CNT_W = $clog2(dl2n_pkg::QUO_W + 1);

	logic [CNT_W-1:0]             cnt_q;
	logic                         first_q;
	logic                         done_q;
	logic [SUM_W-1:0]             rem_q;
	logic [dl2n_pkg::QUO_W-1:0]   quo_q;
	logic [SUM_W:0]               r2;
	logic [SUM_W:0]               r2_sub;
	logic                         ge;

	// first step takes the dividend as is (it never exceeds the divisor)
	assign r2     = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign ge     = r2 >= {1'b0, divisor};
	assign r2_sub = r2 - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q   <= CNT_W'(dl2n_pkg::QUO_W);
				first_q <= 1'b1;
			end else if (cnt_q != '0) begin
				cnt_q   <= cnt_q - CNT_W'(1);
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= SUM_W'(sq);
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? r2_sub[SUM_W-1:0] : r2[SUM_W-1:0];
			quo_q <= {quo_q[dl2n_pkg::QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/dl2n_sqrt.sv =====
// bit-serial integer square root, two radicand bits per cycle
module dl2n_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [dl2n_pkg::QUO_W-1:0]     radicand,
	output logic                           done,
	output logic [dl2n_pkg::ROOT_W-1:0]    root
);

	localparam int ROOT_W = dl2n_pkg::ROOT_W;
	localparam int RAD_W  = dl2n_pkg::RAD_W;
	localparam int REM_W  = ROOT_W + 1;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [RAD_W-1:0]   rad_q;
	logic [ROOT_W-1:0]  root_q;
	logic [REM_W-1:0]   rem_q;
	logic [REM_W+1:0]   r;
	logic [REM_W+1:0]   trial;
	logic [REM_W+1:0]   r_sub;
	logic               ge;

	assign r     = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = r >= trial;
	assign r_sub = r - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(ROOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_W'(radicand);
			root_q <= '0;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			// remainder stays at most twice the root, so it fits rem_q
			rem_q  <= ge ? r_sub[REM_W-1:0] : r[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/dequant_l2_normalize.sv =====
// top level of the dequantized vector l2 normalizer
// Elements come in one request per cycle: each has the zero point taken off, the first
// vector_len differences are stored and their squares summed, any surplus is dropped.
// A request marked is_final starts emission of vector_len results in signed q1.15,
// rounded to nearest and saturated, the last one marked end_of_vector; slots that were
// never filled and every slot of a vector whose scaled norm is under 1e-6 give zero.
// No new element is taken during emission. A check step follows the final element;
// then each stored element is fetched and set up, goes through the bit-serial divider
// for a^2 * 2^32 / sum and the bit-serial square root, and is handed over, while each
// zero slot is only fetched and handed over. A result waits in an output register, so
// the next element is computed, and after the last one new elements are taken, while
// it is still pending. Both request ports stay not ready until the first clock edge
// after reset is released. The element store needs no clearing after reset; only
// filled slots are ever used.
module dequant_l2_normalize #(
	parameter int MAX_DIM = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	dl2n_cfg_if.sink      cfg,
	dl2n_item_if.sink     item,
	dl2n_result_if.source result
);

	localparam int IW = $clog2(MAX_DIM);
	localparam int CW = $clog2(MAX_DIM + 1);
	localparam int SW = dl2n_pkg::SQ_W + $clog2(MAX_DIM);
	localparam int LW = (CW > dl2n_pkg::VLEN_W) ? CW : dl2n_pkg::VLEN_W;
	localparam int PW = dl2n_pkg::SC2_W + SW;

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_CHECK = 7'b0000010,
		ST_FETCH = 7'b0000100,
		ST_PREP  = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_SQRT  = 7'b0100000,
		ST_PUT   = 7'b1000000
	} state_t;

	// magnitude of a stored difference (at most 255)
	function automatic logic [dl2n_pkg::MAG_W-1:0] abs_diff(
		input logic [dl2n_pkg::DIFF_W-1:0] d
	);
		logic [dl2n_pkg::DIFF_W-1:0] neg;
		neg = '0 - d;
		return d[dl2n_pkg::DIFF_W-1] ? neg[dl2n_pkg::MAG_W-1:0] : d[dl2n_pkg::MAG_W-1:0];
	endfunction

	state_t st_q;

	// out of reset, ports may take requests
	logic                         run_q;

	// configuration registers
	logic [dl2n_pkg::VLEN_W-1:0]  vl_q;
	logic [dl2n_pkg::ZP_W-1:0]    zp_q;
	logic [dl2n_pkg::SCALE_W-1:0] scale_q;
	logic [dl2n_pkg::SC2_W-1:0]   sc2_q;
	logic                         scale_small_q;

	// vector state
	logic [CW-1:0]                fill_q;
	logic [SW-1:0]                sum_q;
	logic [CW-1:0]                idx_q;
	logic                         small_q;
	logic                         zero_q;
	logic                         neg_q;
	logic [dl2n_pkg::DIFF_W-1:0]  rd_q;
	logic [dl2n_pkg::DIFF_W-1:0]  store_mem [MAX_DIM];

	// output register
	logic                         res_valid_q;
	logic [dl2n_pkg::UNIT_W-1:0]  unit_q;
	logic [dl2n_pkg::POS_W-1:0]   pos_q;
	logic                         eov_q;

	logic [LW-1:0]                vl_ext;
	logic [LW-1:0]                len_ext;
	logic [CW-1:0]                len;
	logic                         cfg_acc;
	logic                         item_acc;
	logic                         room;
	logic [dl2n_pkg::DIFF_W-1:0]  diff;
	logic [dl2n_pkg::MAG_W-1:0]   mag_in;
	logic [dl2n_pkg::SQ_W-1:0]    sq_in;
	logic [dl2n_pkg::MAG_W-1:0]   mag_rd;
	logic [dl2n_pkg::SQ_W-1:0]    sq_rd;
	logic [PW-1:0]                small_prod;
	logic                         div_start;
	logic                         div_done;
	logic [dl2n_pkg::QUO_W-1:0]   quo;
	logic                         sqrt_done;
	logic [dl2n_pkg::ROOT_W-1:0]  root;
	logic [dl2n_pkg::ROOT_W:0]    root_inc;
	logic [dl2n_pkg::ROOT_W-1:0]  mag_out;
	logic [dl2n_pkg::ROOT_W-1:0]  mag_neg;
	logic [dl2n_pkg::UNIT_W-1:0]  unit_val;
	logic                         put_ok;
	logic                         last;

	// effective length: zero acts as one, anything above MAX_DIM as MAX_DIM
	always_comb begin
		vl_ext = LW'(vl_q);
		if (vl_ext == '0) begin
			len_ext = LW'(1);
		end else if (vl_ext > LW'(MAX_DIM)) begin
			len_ext = LW'(MAX_DIM);
		end else begin
			len_ext = vl_ext;
		end
		len = CW'(len_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	// config port, ready once out of reset; writes must come only while idle, the block does not enforce it
	assign cfg.ready = run_q;
	assign cfg_acc   = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_q          <= dl2n_pkg::VLEN_RESET;
			zp_q          <= dl2n_pkg::ZP_RESET;
			scale_q       <= dl2n_pkg::SCALE_RESET;
			sc2_q         <= '0;
			scale_small_q <= 1'b0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg.index)
					dl2n_pkg::REG_VECTOR_LEN:    vl_q    <= cfg.data[dl2n_pkg::VLEN_W-1:0];
					dl2n_pkg::REG_ZERO_POINT:    zp_q    <= cfg.data[dl2n_pkg::ZP_W-1:0];
					dl2n_pkg::REG_DEQUANT_SCALE: scale_q <= cfg.data;
					default: ;
				endcase
			end
			// scale square precomputed off the config path
			sc2_q         <= dl2n_pkg::SC2_W'(scale_q[8:0]) * dl2n_pkg::SC2_W'(scale_q[8:0]);
			scale_small_q <= scale_q <= dl2n_pkg::SMALL_SCALE_MAX;
		end
	end

	// load side
	assign item.ready = (st_q == ST_LOAD) && run_q;
	assign item_acc   = item.valid && item.ready;
	assign room       = fill_q < len;
	assign diff       = {item.quant_value[dl2n_pkg::QV_W-1], item.quant_value}
		- {zp_q[dl2n_pkg::ZP_W-1], zp_q};
	assign mag_in     = abs_diff(diff);
	assign sq_in      = dl2n_pkg::SQ_W'(mag_in) * dl2n_pkg::SQ_W'(mag_in);

	// emission side
	assign mag_rd     = abs_diff(rd_q);
	assign sq_rd      = dl2n_pkg::SQ_W'(mag_rd) * dl2n_pkg::SQ_W'(mag_rd);
	assign small_prod = PW'(sc2_q) * PW'(sum_q);
	assign div_start  = (st_q == ST_PREP);
	assign put_ok     = !res_valid_q || result.ready;
	assign last       = idx_q == (len - CW'(1));

	// magnitude = (root + 1) / 2, at most 32768
	assign root_inc = {1'b0, root} + (dl2n_pkg::ROOT_W + 1)'(1);
	assign mag_out  = root_inc[dl2n_pkg::ROOT_W:1];
	assign mag_neg  = '0 - mag_out;

	always_comb begin
		if (zero_q) begin
			unit_val = '0;
		end else if (neg_q) begin
			unit_val = mag_neg[dl2n_pkg::UNIT_W-1:0];
		end else if (mag_out > dl2n_pkg::ROOT_W'(dl2n_pkg::UNIT_MAX)) begin
			unit_val = dl2n_pkg::UNIT_MAX;
		end else begin
			unit_val = mag_out[dl2n_pkg::UNIT_W-1:0];
		end
	end

	dl2n_divider #(
		.SUM_W(SW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.sq      (sq_rd),
		.divisor (sum_q),
		.done    (div_done),
		.quo     (quo)
	);

	dl2n_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_done),
		.radicand (quo),
		.done     (sqrt_done),
		.root     (root)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_LOAD;
			fill_q  <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
			small_q <= 1'b0;
			zero_q  <= 1'b0;
			neg_q   <= 1'b0;
		end else begin
			unique case (st_q)
				ST_LOAD: begin
					if (item_acc) begin
						if (room) begin
							fill_q <= fill_q + CW'(1);
							sum_q  <= sum_q + SW'(sq_in);
						end
						if (item.is_final) begin
							idx_q <= '0;
							st_q  <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					// scaled norm under 1e-6 zeroes the whole vector
					small_q <= (sum_q == '0)
						|| (scale_small_q && small_prod <= PW'(dl2n_pkg::SMALL_PROD_MAX));
					st_q    <= ST_FETCH;
				end
				ST_FETCH: begin
					zero_q <= small_q || !(idx_q < fill_q);
					st_q   <= (small_q || !(idx_q < fill_q)) ? ST_PUT : ST_PREP;
				end
				ST_PREP: begin
					neg_q <= rd_q[dl2n_pkg::DIFF_W-1];
					st_q  <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						st_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						st_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (put_ok) begin
						if (last) begin
							fill_q <= '0;
							sum_q  <= '0;
							st_q   <= ST_LOAD;
						end else begin
							idx_q <= idx_q + CW'(1);
							st_q  <= ST_FETCH;
						end
					end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	// element store, registered read
	always_ff @(posedge clk) begin
		if (item_acc && room) begin
			store_mem[fill_q[IW-1:0]] <= diff;
		end
		if (st_q == ST_FETCH) begin
			rd_q <= store_mem[idx_q[IW-1:0]];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((st_q == ST_PUT) && put_ok) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == ST_PUT) && put_ok) begin
			unit_q <= unit_val;
			pos_q  <= dl2n_pkg::POS_W'(idx_q);
			eov_q  <= last;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.unit_value    = unit_q;
	assign result.position      = pos_q;
	assign result.end_of_vector = eov_q;

endmodule
